>>> sv/dte_pkg.sv
// Shared types and constants of the data-transfer execute unit.
// Used by dte_seq and data_transfer_execute_unit_top; no dependencies.
package dte_pkg;

   localparam int MEM_BYTES = 4096;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam logic [16:0]       MEM_LIMIT = 17'(MEM_BYTES);
   localparam logic [MEM_AW-1:0] MEM_LAST  = MEM_AW'(MEM_BYTES - 1);

   localparam int RF_DEPTH = 32;
   localparam int RF_AW    = 5;

   localparam logic [3:0] OP_MOV  = 4'd0;
   localparam logic [3:0] OP_MOVW = 4'd1;
   localparam logic [3:0] OP_LDI  = 4'd2;
   localparam logic [3:0] OP_LD   = 4'd3;
   localparam logic [3:0] OP_LDD  = 4'd4;
   localparam logic [3:0] OP_XCH  = 4'd5;
   localparam logic [3:0] OP_LAS  = 4'd6;
   localparam logic [3:0] OP_LAC  = 4'd7;
   localparam logic [3:0] OP_LAT  = 4'd8;

   localparam logic [1:0] PSEL_Z   = 2'd0;
   localparam logic [1:0] PSEL_Y   = 2'd1;
   localparam logic [1:0] PSEL_X   = 2'd2;
   localparam logic [1:0] PSEL_BAD = 2'd3;

   localparam logic [1:0] MODE_POSTINC = 2'd1;
   localparam logic [1:0] MODE_PREDEC  = 2'd2;

   localparam logic [4:0] PTR_X_LO = 5'd26;
   localparam logic [4:0] PTR_Y_LO = 5'd28;
   localparam logic [4:0] PTR_Z_LO = 5'd30;

   typedef struct packed {
      logic [3:0] req_type;
      logic [4:0] dst_reg;
      logic [4:0] src_reg;
      logic [7:0] imm_data;
      logic [1:0] pointer_sel;
      logic [1:0] addr_mode;
      logic [5:0] displacement;
   } request_type;

   typedef struct packed {
      logic        status;
      logic [4:0]  reg_index;
      logic [7:0]  reg_value;
      logic [7:0]  reg_high_value;
      logic [15:0] mem_address;
      logic        mem_written;
      logic [7:0]  mem_value;
      logic [15:0] pointer_value;
   } result_type;

   typedef struct packed {
      logic             we;
      logic [RF_AW-1:0] waddr;
      logic [7:0]       wdata;
      logic [RF_AW-1:0] raddr;
   } rf_ctl_type;

   typedef struct packed {
      logic              we;
      logic [MEM_AW-1:0] waddr;
      logic [7:0]        wdata;
      logic [MEM_AW-1:0] raddr;
   } dm_ctl_type;

endpackage

>>> sv/dte_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies; used for the register file and the data memory.
module dte_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/dte_seq.sv
// Operation sequencer: reads pointers and operands from the register file RAM,
// accesses the data memory RAM, writes back, and clears both RAMs after reset.
// Depends on dte_pkg.
module dte_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dte_pkg::request_type req,
   output logic                 res_valid,
   input  logic                 res_ready,
   output dte_pkg::result_type  res,
   output dte_pkg::rf_ctl_type  rf_ctl,
   input  logic [7:0]           rf_rdata,
   output dte_pkg::dm_ctl_type  dm_ctl,
   input  logic [7:0]           dm_rdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RA   = 4'd1;
   localparam logic [3:0] S_RB   = 4'd2;
   localparam logic [3:0] S_RC   = 4'd3;
   localparam logic [3:0] S_MR   = 4'd4;
   localparam logic [3:0] S_MD   = 4'd5;
   localparam logic [3:0] S_WL   = 4'd6;
   localparam logic [3:0] S_WH   = 4'd7;
   localparam logic [3:0] S_WI   = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd9;

   logic [3:0]                  state_ff, state_in;
   dte_pkg::request_type        req_ff, req_in;
   dte_pkg::result_type         res_ff, res_in;
   logic [7:0]                  lo_ff, lo_in;
   logic [15:0]                 ptr_ff, ptr_in;
   logic [15:0]                 addr_ff, addr_in;
   logic [7:0]                  rdv_ff, rdv_in;
   logic                        inr_ff, inr_in;
   logic [dte_pkg::MEM_AW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                        clr_busy_ff, clr_busy_in;

   logic        accept;
   logic        bad_req;
   logic        is_atomic;
   logic [4:0]  pidx;
   logic [4:0]  pidx_hi;
   logic [4:0]  movw_s;
   logic [4:0]  movw_d;
   logic [4:0]  ldi_d;
   logic [15:0] base;
   logic [7:0]  mem_byte;
   logic [7:0]  wr_byte;
   logic [15:0] new_ptr;

   assign req_ready = !clr_busy_ff && (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign res       = res_ff;

   assign bad_req = (req.req_type > dte_pkg::OP_LAT)
                 || ((req.req_type == dte_pkg::OP_LD) && (req.pointer_sel == dte_pkg::PSEL_BAD))
                 || ((req.req_type == dte_pkg::OP_LDD) && req.pointer_sel[1]);

   always_comb begin
      is_atomic = req_ff.req_type inside {dte_pkg::OP_XCH, dte_pkg::OP_LAS,
                                          dte_pkg::OP_LAC, dte_pkg::OP_LAT};
      if (is_atomic) begin
         pidx = dte_pkg::PTR_Z_LO;
      end else begin
         case (req_ff.pointer_sel)
            dte_pkg::PSEL_Z: pidx = dte_pkg::PTR_Z_LO;
            dte_pkg::PSEL_Y: pidx = dte_pkg::PTR_Y_LO;
            default:         pidx = dte_pkg::PTR_X_LO;
         endcase
      end
   end

   assign pidx_hi  = {pidx[4:1], 1'b1};
   assign movw_s   = {req_ff.src_reg[3:0], 1'b0};
   assign movw_d   = {req_ff.dst_reg[3:0], 1'b0};
   assign ldi_d    = {1'b1, req_ff.dst_reg[3:0]};
   assign base     = {rf_rdata, lo_ff};
   assign mem_byte = inr_ff ? dm_rdata : 8'd0;

   always_comb begin
      case (req_ff.req_type)
         dte_pkg::OP_XCH: wr_byte = rdv_ff;
         dte_pkg::OP_LAS: wr_byte = rdv_ff | mem_byte;
         dte_pkg::OP_LAC: wr_byte = ~rdv_ff & mem_byte;
         default:         wr_byte = rdv_ff ^ mem_byte;
      endcase
      if (req_ff.req_type == dte_pkg::OP_LD && req_ff.addr_mode == dte_pkg::MODE_POSTINC) begin
         new_ptr = addr_ff + 16'd1;
      end else if (req_ff.req_type == dte_pkg::OP_LDD) begin
         new_ptr = ptr_ff;
      end else begin
         new_ptr = addr_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      res_in      = res_ff;
      lo_in       = lo_ff;
      ptr_in      = ptr_ff;
      addr_in     = addr_ff;
      rdv_in      = rdv_ff;
      inr_in      = inr_ff;
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      rf_ctl      = '0;
      dm_ctl      = '0;
      res_valid   = 1'b0;

      if (clr_busy_ff) begin
         rf_ctl.we    = 1'b1;
         rf_ctl.waddr = clr_cnt_ff[dte_pkg::RF_AW-1:0];
         dm_ctl.we    = 1'b1;
         dm_ctl.waddr = clr_cnt_ff;
         clr_cnt_in   = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == dte_pkg::MEM_LAST) begin
            clr_busy_in = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req;
               res_in = '0;
               if (bad_req) begin
                  res_in.status = 1'b1;
                  state_in      = S_FIN;
               end else if (req.req_type == dte_pkg::OP_LDI) begin
                  state_in = S_WI;
               end else begin
                  state_in = S_RA;
               end
            end
         end
         S_RA: begin
            if (req_ff.req_type == dte_pkg::OP_MOV) begin
               rf_ctl.raddr = req_ff.src_reg;
            end else if (req_ff.req_type == dte_pkg::OP_MOVW) begin
               rf_ctl.raddr = movw_s;
            end else begin
               rf_ctl.raddr = pidx;
            end
            state_in = S_RB;
         end
         S_RB: begin
            rf_ctl.raddr = (req_ff.req_type == dte_pkg::OP_MOVW) ? (movw_s | 5'd1) : pidx_hi;
            if (req_ff.req_type == dte_pkg::OP_MOV) begin
               rf_ctl.we        = 1'b1;
               rf_ctl.waddr     = req_ff.dst_reg;
               rf_ctl.wdata     = rf_rdata;
               res_in.reg_index = req_ff.dst_reg;
               res_in.reg_value = rf_rdata;
               state_in         = S_FIN;
            end else begin
               lo_in    = rf_rdata;
               state_in = S_RC;
            end
         end
         S_RC: begin
            rf_ctl.raddr = req_ff.dst_reg;
            if (req_ff.req_type == dte_pkg::OP_MOVW) begin
               rf_ctl.we             = 1'b1;
               rf_ctl.waddr          = movw_d;
               rf_ctl.wdata          = lo_ff;
               res_in.reg_index      = movw_d;
               res_in.reg_value      = lo_ff;
               res_in.reg_high_value = rf_rdata;
               state_in              = S_WH;
            end else begin
               ptr_in = base;
               if (req_ff.req_type == dte_pkg::OP_LD
                   && req_ff.addr_mode == dte_pkg::MODE_PREDEC) begin
                  addr_in = base - 16'd1;
               end else if (req_ff.req_type == dte_pkg::OP_LDD) begin
                  addr_in = base + {10'd0, req_ff.displacement};
               end else begin
                  addr_in = base;
               end
               state_in = S_MR;
            end
         end
         S_MR: begin
            dm_ctl.raddr = addr_ff[dte_pkg::MEM_AW-1:0];
            inr_in       = {1'b0, addr_ff} < dte_pkg::MEM_LIMIT;
            rdv_in       = rf_rdata;
            state_in     = S_MD;
         end
         S_MD: begin
            rf_ctl.we            = 1'b1;
            rf_ctl.waddr         = req_ff.dst_reg;
            rf_ctl.wdata         = mem_byte;
            res_in.reg_index     = req_ff.dst_reg;
            res_in.reg_value     = mem_byte;
            res_in.mem_address   = addr_ff;
            res_in.pointer_value = new_ptr;
            ptr_in               = new_ptr;
            if (is_atomic && inr_ff) begin
               dm_ctl.we          = 1'b1;
               dm_ctl.waddr       = addr_ff[dte_pkg::MEM_AW-1:0];
               dm_ctl.wdata       = wr_byte;
               res_in.mem_written = 1'b1;
               res_in.mem_value   = wr_byte;
            end
            if (req_ff.req_type == dte_pkg::OP_LD
                && (req_ff.addr_mode == dte_pkg::MODE_POSTINC
                    || req_ff.addr_mode == dte_pkg::MODE_PREDEC)) begin
               state_in = S_WL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_WL: begin
            rf_ctl.we    = 1'b1;
            rf_ctl.waddr = pidx;
            rf_ctl.wdata = ptr_ff[7:0];
            state_in     = S_WH;
         end
         S_WH: begin
            rf_ctl.we = 1'b1;
            if (req_ff.req_type == dte_pkg::OP_MOVW) begin
               rf_ctl.waddr = movw_d | 5'd1;
               rf_ctl.wdata = res_ff.reg_high_value;
            end else begin
               rf_ctl.waddr = pidx_hi;
               rf_ctl.wdata = ptr_ff[15:8];
            end
            state_in = S_FIN;
         end
         S_WI: begin
            rf_ctl.we        = 1'b1;
            rf_ctl.waddr     = ldi_d;
            rf_ctl.wdata     = req_ff.imm_data;
            res_in.reg_index = ldi_d;
            res_in.reg_value = req_ff.imm_data;
            state_in         = S_FIN;
         end
         S_FIN: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
      req_ff  <= req_in;
      res_ff  <= res_in;
      lo_ff   <= lo_in;
      ptr_ff  <= ptr_in;
      addr_ff <= addr_in;
      rdv_ff  <= rdv_in;
      inr_ff  <= inr_in;
   end

`ifndef SYNTHESIS
   a_clear_holds_idle: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (state_ff == S_IDLE) && !res_valid)
      else $error("operation in flight during memory clear");

   a_dm_write_source: assert property (@(posedge clock) disable iff (reset)
      dm_ctl.we |-> clr_busy_ff || (state_ff == S_MD))
      else $error("data memory written outside clear or execute step");

   a_dm_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (dm_ctl.we && !clr_busy_ff) |-> inr_ff && is_atomic)
      else $error("data memory write out of range or by a load");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted beat did not start an operation");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_ready) |=> res_valid && $stable(res_ff))
      else $error("pending result dropped or changed");
`endif

endmodule

>>> sv/data_transfer_execute_unit_top.sv
// Top level of the data-transfer execute unit: stream ports, RAMs and output register.
// Depends on dte_pkg, dte_ram and dte_seq.
//
// Usage:
//   req_* carries one decoded MOV/MOVW/LDI/LD/LDD/XCH/LAS/LAC/LAT operation per beat;
//   rsp_* returns exactly one result beat per request beat, in order.
//   The register file (32 bytes) and data memory sit in synchronous RAMs with
//   registered read data; every operation but LDI and a rejected one reads the
//   operand and pointer bytes it needs one byte a cycle through the single register
//   file read port, then writes back. A rejected operation goes straight to its
//   result beat, and no new request beat is taken while an operation is in flight.
//   After reset the block sweeps both RAMs to zero, one entry a cycle over the
//   MEM_BYTES (4096) data memory entries, with req_tready low.
//   A finished result waits in the output register while rsp_tready is low; the
//   next request is still taken, and its result waits for the register to empty.
module data_transfer_execute_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // dst_reg[4:0], src_reg[9:5], imm_data[17:10], pointer_sel[19:18],
   // addr_mode[21:20], displacement[27:22], zero[31:28]
   input  logic [31:0] req_tdata,
   // req_type[3:0]
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // reg_index[4:0], reg_value[12:5], reg_high_value[20:13], mem_address[36:21],
   // mem_written[37], mem_value[45:38], pointer_value[61:46], zero[63:62]
   output logic [63:0] rsp_tdata,
   // status[0]
   output logic [0:0]  rsp_tuser
);

   dte_pkg::request_type req;
   dte_pkg::result_type  res;
   dte_pkg::result_type  rsp_res_ff, rsp_res_in;
   dte_pkg::rf_ctl_type  rf_ctl;
   dte_pkg::dm_ctl_type  dm_ctl;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic                 res_valid;
   logic                 res_ready;
   logic [7:0]           rf_rdata;
   logic [7:0]           dm_rdata;

   always_comb begin
      req.req_type     = req_tuser;
      req.dst_reg      = req_tdata[4:0];
      req.src_reg      = req_tdata[9:5];
      req.imm_data     = req_tdata[17:10];
      req.pointer_sel  = req_tdata[19:18];
      req.addr_mode    = req_tdata[21:20];
      req.displacement = req_tdata[27:22];
   end

   dte_ram #(
      .DEPTH(dte_pkg::RF_DEPTH),
      .WIDTH(8)
   ) u_regfile (
      .clock(clock),
      .we   (rf_ctl.we),
      .waddr(rf_ctl.waddr),
      .wdata(rf_ctl.wdata),
      .raddr(rf_ctl.raddr),
      .rdata(rf_rdata)
   );

   dte_ram #(
      .DEPTH(dte_pkg::MEM_BYTES),
      .WIDTH(8)
   ) u_datamem (
      .clock(clock),
      .we   (dm_ctl.we),
      .waddr(dm_ctl.waddr),
      .wdata(dm_ctl.wdata),
      .raddr(dm_ctl.raddr),
      .rdata(dm_rdata)
   );

   dte_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req      (req),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res      (res),
      .rf_ctl   (rf_ctl),
      .rf_rdata (rf_rdata),
      .dm_ctl   (dm_ctl),
      .dm_rdata (dm_rdata)
   );

   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_res_in    = rsp_res_ff;
      if (res_ready) begin
         rsp_tvalid_in = res_valid;
         if (res_valid) begin
            rsp_res_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {2'b00,
                        rsp_res_ff.pointer_value,
                        rsp_res_ff.mem_value,
                        rsp_res_ff.mem_written,
                        rsp_res_ff.mem_address,
                        rsp_res_ff.reg_high_value,
                        rsp_res_ff.reg_value,
                        rsp_res_ff.reg_index};

endmodule

>>> tb/sv/data_transfer_execute_unit_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for data_transfer_execute_unit_top: directed and random
// load/store/move beats checked against an internal register-file and memory image.
// Depends on dte_pkg and the data_transfer_execute_unit_top RTL.
module data_transfer_execute_unit_top_test;

   localparam logic [3:0] OP_UNDEF_LO   = 4'd9;
   localparam logic [3:0] OP_UNDEF_HI   = 4'd15;
   localparam logic [1:0] MODE_PLAIN    = 2'd0;
   localparam logic [1:0] MODE_SPARE    = 2'd3;
   localparam logic       STATUS_REJECT = 1'b1;
   localparam int         RANDOM_OPS    = 1500;

   typedef struct packed {
      logic                 drain_first;
      dte_pkg::request_type op;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   logic [7:0] reg_file_img [dte_pkg::RF_DEPTH]  = '{default: 8'h00};
   logic [7:0] data_mem_img [dte_pkg::MEM_BYTES] = '{default: 8'h00};

   stim_type            op_q[$];
   dte_pkg::result_type result_due_q[$];

   logic req_beat = 1'b0;
   logic rsp_beat = 1'b0;
   logic rsp_hold = 1'b0;
   bit   req_quiet = 1'b0;
   bit   rsp_quiet = 1'b0;
   int   req_idle = 0;
   int   rsp_idle = 0;
   int   ops_total = 0;
   int   ops_accepted = 0;
   int   results_checked = 0;
   int   fail_count = 0;
   int   reject_count = 0;
   int   mem_write_count = 0;

   data_transfer_execute_unit_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic logic [15:0] pair_get(logic [4:0] lo);
      return {reg_file_img[lo + 5'd1], reg_file_img[lo]};
   endfunction

   function automatic logic [7:0] mem_get(logic [15:0] addr);
      if ({1'b0, addr} < dte_pkg::MEM_LIMIT) return data_mem_img[addr[dte_pkg::MEM_AW-1:0]];
      return 8'h00;
   endfunction

   // Execute one operation on the image and return the beat it must produce.
   function automatic dte_pkg::result_type execute_op(dte_pkg::request_type r);
      dte_pkg::result_type res;
      logic [4:0]  ptr_lo;
      logic [4:0]  d;
      logic [15:0] addr;
      logic [7:0]  m;
      logic [7:0]  w;
      res = '0;
      case (r.req_type)
         dte_pkg::OP_MOV: begin
            reg_file_img[r.dst_reg] = reg_file_img[r.src_reg];
            res.reg_index = r.dst_reg;
            res.reg_value = reg_file_img[r.dst_reg];
         end
         dte_pkg::OP_MOVW: begin
            d = {r.dst_reg[3:0], 1'b0};
            ptr_lo = {r.src_reg[3:0], 1'b0};
            res.reg_value = reg_file_img[ptr_lo];
            res.reg_high_value = reg_file_img[ptr_lo + 5'd1];
            reg_file_img[d] = res.reg_value;
            reg_file_img[d + 5'd1] = res.reg_high_value;
            res.reg_index = d;
         end
         dte_pkg::OP_LDI: begin
            d = {1'b1, r.dst_reg[3:0]};
            reg_file_img[d] = r.imm_data;
            res.reg_index = d;
            res.reg_value = r.imm_data;
         end
         dte_pkg::OP_LD, dte_pkg::OP_LDD: begin
            if (r.pointer_sel == dte_pkg::PSEL_BAD
                || (r.req_type == dte_pkg::OP_LDD && r.pointer_sel == dte_pkg::PSEL_X))
               res.status = STATUS_REJECT;
            else begin
               ptr_lo = (r.pointer_sel == dte_pkg::PSEL_Z) ? dte_pkg::PTR_Z_LO :
                        (r.pointer_sel == dte_pkg::PSEL_Y) ? dte_pkg::PTR_Y_LO :
                                                             dte_pkg::PTR_X_LO;
               addr = pair_get(ptr_lo);
               if (r.req_type == dte_pkg::OP_LDD) begin
                  res.pointer_value = addr;
                  addr = addr + 16'(r.displacement);
               end else if (r.addr_mode == dte_pkg::MODE_PREDEC)
                  addr = addr - 16'd1;
               res.mem_address = addr;
               res.reg_value = mem_get(addr);
               res.reg_index = r.dst_reg;
               reg_file_img[r.dst_reg] = res.reg_value;
               if (r.req_type == dte_pkg::OP_LD) begin
                  if (r.addr_mode == dte_pkg::MODE_POSTINC) addr = addr + 16'd1;
                  // pointer write-back wins over a load into the pointer itself
                  if (r.addr_mode == dte_pkg::MODE_POSTINC
                      || r.addr_mode == dte_pkg::MODE_PREDEC) begin
                     reg_file_img[ptr_lo] = addr[7:0];
                     reg_file_img[ptr_lo + 5'd1] = addr[15:8];
                  end
                  res.pointer_value = addr;
               end
            end
         end
         dte_pkg::OP_XCH, dte_pkg::OP_LAS, dte_pkg::OP_LAC, dte_pkg::OP_LAT: begin
            addr = pair_get(dte_pkg::PTR_Z_LO);
            m = mem_get(addr);
            case (r.req_type)
               dte_pkg::OP_XCH: w = reg_file_img[r.dst_reg];
               dte_pkg::OP_LAS: w = reg_file_img[r.dst_reg] | m;
               dte_pkg::OP_LAC: w = ~reg_file_img[r.dst_reg] & m;
               default:         w = reg_file_img[r.dst_reg] ^ m;
            endcase
            if ({1'b0, addr} < dte_pkg::MEM_LIMIT) begin
               data_mem_img[addr[dte_pkg::MEM_AW-1:0]] = w;
               res.mem_written = 1'b1;
               res.mem_value = w;
            end
            reg_file_img[r.dst_reg] = m;
            res.reg_index = r.dst_reg;
            res.reg_value = m;
            res.mem_address = addr;
            res.pointer_value = addr;
         end
         default: res.status = STATUS_REJECT;
      endcase
      return res;
   endfunction

   function automatic dte_pkg::request_type mk(logic [3:0] kind, logic [4:0] dst,
                                               logic [4:0] src, logic [7:0] imm,
                                               logic [1:0] psel, logic [1:0] mode,
                                               logic [5:0] disp);
      dte_pkg::request_type r;
      r.req_type = kind;
      r.dst_reg = dst;
      r.src_reg = src;
      r.imm_data = imm;
      r.pointer_sel = psel;
      r.addr_mode = mode;
      r.displacement = disp;
      return r;
   endfunction

   // Mostly pointer setup and memory traffic in a small window so data gets reused.
   function automatic dte_pkg::request_type random_op();
      dte_pkg::request_type r;
      int pick;
      r = dte_pkg::request_type'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         r.req_type = dte_pkg::OP_LDI;
         r.dst_reg = {1'($urandom_range(0, 1)), 4'($urandom_range(10, 15))};
         if (r.dst_reg[0] && $urandom_range(0, 7) != 0)
            r.imm_data = 8'($urandom_range(0, 1));
      end else if (pick < 25) r.req_type = dte_pkg::OP_LDI;
      else if (pick < 32) r.req_type = dte_pkg::OP_MOV;
      else if (pick < 38) r.req_type = dte_pkg::OP_MOVW;
      else if (pick < 60) r.req_type = dte_pkg::OP_LD;
      else if (pick < 72) r.req_type = dte_pkg::OP_LDD;
      else if (pick < 97) r.req_type = 4'($urandom_range(dte_pkg::OP_XCH, dte_pkg::OP_LAT));
      else r.req_type = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      return r;
   endfunction

   function automatic string fmt_result(dte_pkg::result_type r);
      return $sformatf("st=%0d idx=%0d val=%h hi=%h addr=%h mw=%0d mv=%h ptr=%h",
                       r.status, r.reg_index, r.reg_value, r.reg_high_value,
                       r.mem_address, r.mem_written, r.mem_value, r.pointer_value);
   endfunction

   task automatic note_fail(string what, dte_pkg::result_type want,
                            dte_pkg::result_type seen);
      fail_count++;
      if (fail_count <= 10) begin
         $display("ERROR %0t: %s", $realtime, what);
         $display("   expected %s", fmt_result(want));
         $display("   actual   %s", fmt_result(seen));
      end
   endtask

   // Driver: present the next beat at the falling edge, hold it until taken.
   always @(negedge clock) begin
      stim_type nxt;
      if (!reset && !(req_tvalid && !req_beat)) begin
         if (req_beat) begin
            if ($urandom_range(0, 39) == 0) req_quiet = !req_quiet;
            req_idle = req_quiet ? 0 : $urandom_range(0, 16);
         end
         if (req_idle > 0) begin
            req_idle--;
            req_tvalid <= 1'b0;
         end else if (op_q.size() != 0 &&
                      !(op_q[0].drain_first && result_due_q.size() != 0)) begin
            nxt = op_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.op.req_type;
            req_tdata <= {4'b0, nxt.op.displacement, nxt.op.addr_mode, nxt.op.pointer_sel,
                          nxt.op.imm_data, nxt.op.src_reg, nxt.op.dst_reg};
         end else
            req_tvalid <= 1'b0;
      end
   end

   // Receiver: stall for a drawn number of cycles after each result beat.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_beat) begin
            if ($urandom_range(0, 39) == 0) rsp_quiet = !rsp_quiet;
            rsp_idle = rsp_quiet ? 0 : $urandom_range(0, 16);
         end
         if (rsp_hold)
            rsp_tready <= 1'b0;
         else if (rsp_idle > 0) begin
            rsp_idle--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= 1'b1;
      end
   end

   // Monitor: check result beats, predict accepted request beats.
   always @(posedge clock) begin
      dte_pkg::result_type  seen;
      dte_pkg::result_type  want;
      dte_pkg::request_type taken;
      string fld;
      req_beat <= !reset && req_tvalid && req_tready;
      rsp_beat <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.status = rsp_tuser[0];
         seen.reg_index = rsp_tdata[4:0];
         seen.reg_value = rsp_tdata[12:5];
         seen.reg_high_value = rsp_tdata[20:13];
         seen.mem_address = rsp_tdata[36:21];
         seen.mem_written = rsp_tdata[37];
         seen.mem_value = rsp_tdata[45:38];
         seen.pointer_value = rsp_tdata[61:46];
         if (result_due_q.size() == 0)
            note_fail("result beat with nothing outstanding", '0, seen);
         else begin
            want = result_due_q.pop_front();
            results_checked++;
            if (want.status == STATUS_REJECT) reject_count++;
            if (want.mem_written) mem_write_count++;
            fld = "";
            if (seen.status != want.status) fld = {fld, " status"};
            if (seen.reg_index != want.reg_index) fld = {fld, " reg_index"};
            if (seen.reg_value != want.reg_value) fld = {fld, " reg_value"};
            if (seen.reg_high_value != want.reg_high_value) fld = {fld, " reg_high_value"};
            if (seen.mem_address != want.mem_address) fld = {fld, " mem_address"};
            if (seen.mem_written != want.mem_written) fld = {fld, " mem_written"};
            if (seen.mem_value != want.mem_value) fld = {fld, " mem_value"};
            if (seen.pointer_value != want.pointer_value) fld = {fld, " pointer_value"};
            if (fld != "")
               note_fail($sformatf("result %0d wrong:%s", results_checked, fld), want, seen);
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         taken = {req_tuser, req_tdata[4:0], req_tdata[9:5], req_tdata[17:10],
                  req_tdata[19:18], req_tdata[21:20], req_tdata[27:22]};
         result_due_q.push_back(execute_op(taken));
         ops_accepted++;
      end
   end

   // Hold off the result side long enough for the block to back up its input.
   initial begin
      wait (ops_accepted >= 500);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      // Z = 0x0010, r16 = 0xFF
      op_q.push_back({1'b0, mk(dte_pkg::OP_LDI, 5'd14, 5'd0, 8'h10,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LDI, 5'd31, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LDI, 5'd0, 5'd0, 8'hFF,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_XCH, 5'd16, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LAS, 5'd16, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LAC, 5'd16, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LAT, 5'd16, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LD, 5'd0, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LD, 5'd1, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, dte_pkg::MODE_POSTINC, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LD, 5'd2, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, dte_pkg::MODE_PREDEC, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LD, 5'd3, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, MODE_SPARE, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LDD, 5'd4, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd63)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LDD, 5'd5, 5'd0, 8'h00,
                               dte_pkg::PSEL_Y, MODE_PLAIN, 6'd16)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LDD, 5'd5, 5'd0, 8'h00,
                               dte_pkg::PSEL_X, MODE_PLAIN, 6'd1)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LD, 5'd5, 5'd0, 8'h00,
                               dte_pkg::PSEL_BAD, MODE_PLAIN, 6'd0)});
      // X wraps below zero, then back up past 0xFFFF
      op_q.push_back({1'b0, mk(dte_pkg::OP_LD, 5'd6, 5'd0, 8'h00,
                               dte_pkg::PSEL_X, dte_pkg::MODE_PREDEC, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LD, 5'd7, 5'd0, 8'h00,
                               dte_pkg::PSEL_X, dte_pkg::MODE_POSTINC, 6'd0)});
      // loads into the pointer's own registers
      op_q.push_back({1'b0, mk(dte_pkg::OP_LD, 5'd28, 5'd0, 8'h00,
                               dte_pkg::PSEL_Y, dte_pkg::MODE_POSTINC, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LD, 5'd31, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, dte_pkg::MODE_PREDEC, 6'd0)});
      // Z beyond the memory: read gives zero, write is dropped
      op_q.push_back({1'b0, mk(dte_pkg::OP_LDI, 5'd0, 5'd0, 8'h80,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_MOV, 5'd31, 5'd16, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_LAS, 5'd5, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_MOV, 5'd0, 5'd31, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(dte_pkg::OP_MOVW, 5'd16, 5'd31, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      op_q.push_back({1'b0, mk(OP_UNDEF_HI, 5'd31, 5'd31, 8'hFF,
                               dte_pkg::PSEL_BAD, MODE_SPARE, 6'd63)});
      op_q.push_back({1'b0, mk(OP_UNDEF_LO, 5'd0, 5'd0, 8'h00,
                               dte_pkg::PSEL_Z, MODE_PLAIN, 6'd0)});
      for (int i = 0; i < RANDOM_OPS; i++)
         op_q.push_back({(i == 0 || i == 750) ? 1'b1 : 1'b0, random_op()});
      ops_total = op_q.size();

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      wait (ops_accepted == ops_total);
      while (result_due_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      $display("run: %0d operations executed, %0d results checked", ops_accepted,
               results_checked);
      $display("run: %0d rejected, %0d memory writes, %0d mismatches", reject_count,
               mem_write_count, fail_count);
      if (fail_count == 0 && result_due_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
